// ===== src/apwm_pkg.sv =====
package apwm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_W       = 24;
  localparam int SYM_W       = 8;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 6;
  localparam int THR_W       = 7;
  localparam int CNT_W       = 6;
  localparam int MASK_W      = 32;
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
  localparam int PROD_W      = 12;
  localparam int PERCENT     = 100;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [THR_W-1:0] THR_RESET = 7'd100;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  // output queue
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W       = FIFO_CW + 1;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_SYMBOL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_LENGTH    = 1'b1
  } cfg_reg_t;

  // shared control for the row of compare cells
  typedef struct packed {
    logic             shift;
    logic [SYM_W-1:0] sym;
    logic             sym_valid;
    logic             clear;
  } chain_ctrl_t;

  // one window evaluation launched from the cell row
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] start;
    logic             closes;
  } eval_t;

  typedef struct packed {
    logic [POS_W-1:0]  start_position;
    logic [CNT_W-1:0]  match_count;
    logic [MASK_W-1:0] match_mask;
    logic              last_of_run;
  } result_t;

endpackage

// ===== src/apwm_channel_if.sv =====
interface apwm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [apwm_pkg::IDX_W-1:0]  pattern_index;
  logic [apwm_pkg::SYM_W-1:0]  symbol;
  logic                        end_of_sequence;

  modport source (output valid, action, pattern_index, symbol, end_of_sequence,
                  input ready);
  modport sink   (input valid, action, pattern_index, symbol, end_of_sequence,
                  output ready);
endinterface

interface apwm_out_if;
  logic                         valid;
  logic                         ready;
  logic [apwm_pkg::POS_W-1:0]   start_position;
  logic [apwm_pkg::CNT_W-1:0]   match_count;
  logic [apwm_pkg::MASK_W-1:0]  match_mask;
  logic                         last_of_run;

  modport source (output valid, start_position, match_count, match_mask, last_of_run,
                  input ready);
  modport sink   (input valid, start_position, match_count, match_mask, last_of_run,
                  output ready);
endinterface

// ===== src/apwm_cell.sv =====
module apwm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apwm_pkg::chain_ctrl_t      ctrl,
  input  logic                       inject,
  input  logic                       in_use,
  input  logic                       pat_we,
  input  logic [apwm_pkg::SYM_W-1:0] pat_sym,
  input  logic [apwm_pkg::SYM_W-1:0] nb_sym,
  input  logic                       nb_valid,
  output logic [apwm_pkg::SYM_W-1:0] sym,
  output logic                       valid,
  output logic                       hit
);

  logic [apwm_pkg::SYM_W-1:0] pat_r;
  logic [apwm_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic                       valid_r, valid_nxt;

  always_comb begin
    sym_nxt   = sym_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      if (inject) begin
        sym_nxt   = ctrl.sym;
        valid_nxt = ctrl.sym_valid;
      end else begin
        // take the neighbor's character; drop stale ones on a fresh sequence
        sym_nxt   = nb_sym;
        valid_nxt = nb_valid & ~ctrl.clear;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    if (pat_we) begin
      pat_r <= pat_sym;
    end
  end

  assign sym   = sym_r;
  assign valid = valid_r;
  assign hit   = in_use & valid_r & (pat_r == sym_r);

endmodule

// ===== src/apwm_score.sv =====
module apwm_score (
  input  logic                             clk,
  input  logic                             rst_n,
  input  apwm_pkg::eval_t                  ev,
  input  logic [apwm_pkg::PATTERN_MAX-1:0] hits,
  input  logic [apwm_pkg::PROD_W-1:0]      thr_len,
  output logic                             push,
  output apwm_pkg::result_t                push_word,
  output logic [1:0]                       occ
);

  function automatic logic [apwm_pkg::CNT_W-1:0] popcount(
    input logic [apwm_pkg::PATTERN_MAX-1:0] v
  );
    logic [apwm_pkg::CNT_W-1:0] total;
    logic [3:0]                 part;
    total = '0;
    for (int g = 0; g < apwm_pkg::PATTERN_MAX / 8; g++) begin
      part = '0;
      for (int b = 0; b < 8; b++) begin
        part = part + 4'(v[g*8 + b]);
      end
      total = total + apwm_pkg::CNT_W'(part);
    end
    return total;
  endfunction

  logic                              v1_r, v2_r;
  logic [apwm_pkg::POS_W-1:0]        start1_r, start2_r;
  logic                              closes1_r, closes2_r;
  logic [apwm_pkg::PATTERN_MAX-1:0]  mask1_r, mask2_r;
  logic [apwm_pkg::CNT_W-1:0]        count2_r;

  logic                              pv_r, pv_nxt;
  logic                              pdone_r, pdone_nxt;
  apwm_pkg::result_t                 pword_r, pword_nxt;

  logic [apwm_pkg::PROD_W-1:0]       scaled;
  logic                              pass;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ev.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid) begin
      mask1_r   <= hits;
      start1_r  <= ev.start;
      closes1_r <= ev.closes;
    end
    if (v1_r) begin
      mask2_r   <= mask1_r;
      count2_r  <= popcount(mask1_r);
      start2_r  <= start1_r;
      closes2_r <= closes1_r;
    end
  end

  assign scaled = apwm_pkg::PROD_W'(count2_r) * apwm_pkg::PROD_W'(apwm_pkg::PERCENT);
  assign pass   = v2_r && (scaled >= thr_len);

  // hold the latest passing window until we know whether it ends its run
  assign push = pv_r && (pdone_r || pass);

  always_comb begin
    pv_nxt    = pv_r;
    pdone_nxt = pdone_r;
    pword_nxt = pword_r;
    if (pass) begin
      pv_nxt                   = 1'b1;
      pdone_nxt                = closes2_r;
      pword_nxt.start_position = start2_r;
      pword_nxt.match_count    = count2_r;
      pword_nxt.match_mask     = apwm_pkg::MASK_W'(mask2_r);
      pword_nxt.last_of_run    = 1'b0;
    end else if (push) begin
      pv_nxt = 1'b0;
    end else if (v2_r && closes2_r && pv_r) begin
      pdone_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      pdone_r <= 1'b0;
    end else begin
      pv_r    <= pv_nxt;
      pdone_r <= pdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pword_r <= pword_nxt;
  end

  always_comb begin
    push_word             = pword_r;
    push_word.last_of_run = pdone_r;
  end

  assign occ = 2'(v1_r) + 2'(v2_r) + 2'(pv_r);

endmodule

// ===== src/apwm_fifo.sv =====
module apwm_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  apwm_pkg::result_t            push_word,
  input  logic                         pop_ready,
  output logic                         head_valid,
  output apwm_pkg::result_t            head_word,
  output logic [apwm_pkg::FIFO_CW-1:0] count
);

  apwm_pkg::result_t                 mem_r [apwm_pkg::FIFO_DEPTH];
  logic [apwm_pkg::FIFO_AW-1:0]      wr_r, rd_r;
  logic [apwm_pkg::FIFO_CW-1:0]      cnt_r, cnt_nxt;
  logic                              pop;

  assign head_valid = (cnt_r != '0);
  assign head_word  = mem_r[rd_r];
  assign pop        = head_valid & pop_ready;
  assign count      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_word;
    end
  end

endmodule

// ===== src/approximate_pattern_window_matcher_unit.sv =====
// Approximate pattern matcher over a byte stream. Load the pattern with action 0
// words (one character each, one per cycle while ready), then stream sequence
// characters with action 1. Each pattern position lives in its own compare cell;
// sequence characters march down the row of cells, so each shift of the row lines
// up one window against the pattern, and a start is reported when 100*matches >=
// threshold_percent*pattern_length. Rate: one sequence character per cycle while
// streaming and the queue has room. After the character flagged end_of_sequence,
// the row shifts on without new characters to line up each partial window in turn.
// A write of pattern_length holds off input while the row is realigned from the
// character history. Results leave through an 8-word queue, at most one per cycle,
// after the scoring registers; input also stalls when that queue could overflow.
module approximate_pattern_window_matcher_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  apwm_in_if.sink                         in_ch,
  apwm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [apwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_STREAM = 3'b001,
    ST_FLUSH  = 3'b010,
    ST_ALIGN  = 3'b100
  } state_t;

  localparam int PM = apwm_pkg::PATTERN_MAX;

  state_t                           state_r, state_nxt;
  logic [apwm_pkg::THR_W-1:0]       thr_r;
  logic [apwm_pkg::LEN_W-1:0]       len_r;
  logic [apwm_pkg::PROD_W-1:0]      thr_len_r;
  logic [apwm_pkg::POS_W-1:0]       seqpos_r, seqpos_nxt;
  logic [apwm_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [apwm_pkg::LEN_W-1:0]       step_r, step_nxt;
  logic [apwm_pkg::LEN_W-1:0]       skip_r, skip_nxt;
  logic [apwm_pkg::POS_W-1:0]       fstart_r, fstart_nxt;
  logic [apwm_pkg::SYM_W-1:0]       hist_r [PM];
  apwm_pkg::eval_t                  ev_r, ev_nxt;
  apwm_pkg::chain_ctrl_t            ctrl;

  logic [apwm_pkg::LEN_W-1:0]       len_eff, len_m1, top, align_idx;
  logic [apwm_pkg::POS_W-1:0]       seqpos_inc, start0;
  logic [apwm_pkg::FILL_W-1:0]      fill_inc;
  logic                             full, flush_last, align_valid;
  logic                             acc, acc_pat, acc_sym, cfg_len_we;

  logic [apwm_pkg::FIFO_CW-1:0]     fifo_cnt;
  logic [1:0]                       score_occ;
  logic [apwm_pkg::OCC_W-1:0]       occ;
  logic                             credit_ok;

  logic [apwm_pkg::SYM_W-1:0]       cell_sym   [PM];
  logic                             cell_valid [PM];
  logic [PM-1:0]                    hits;

  logic                             push;
  apwm_pkg::result_t                push_word, head_word;

  // effective length: zero acts as one, larger values clamp to the row size
  always_comb begin
    if (len_r == '0) begin
      len_eff = apwm_pkg::LEN_W'(1);
    end else if (len_r > apwm_pkg::LEN_W'(PM)) begin
      len_eff = apwm_pkg::LEN_W'(PM);
    end else begin
      len_eff = len_r;
    end
  end
  assign len_m1 = len_eff - 1'b1;

  assign occ       = apwm_pkg::OCC_W'(fifo_cnt) + apwm_pkg::OCC_W'(ev_r.valid)
                   + apwm_pkg::OCC_W'(score_occ);
  assign credit_ok = (occ < apwm_pkg::OCC_W'(apwm_pkg::FIFO_DEPTH));

  assign in_ch.ready = (state_r == ST_STREAM) && credit_ok;
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_pat     = acc && (in_ch.action == apwm_pkg::ACT_PATTERN);
  assign acc_sym     = acc && (in_ch.action == apwm_pkg::ACT_SYMBOL);
  assign cfg_len_we  = cfg_we && (cfg_index == apwm_pkg::CFG_LENGTH);

  assign seqpos_inc = seqpos_r + 1'b1;
  assign fill_inc   = (fill_r < apwm_pkg::FILL_W'(PM)) ? fill_r + 1'b1 : fill_r;
  assign full       = (apwm_pkg::LEN_W'(fill_inc) >= len_eff);
  assign top        = full ? len_eff : apwm_pkg::LEN_W'(fill_inc);
  assign start0     = seqpos_inc - apwm_pkg::POS_W'(len_m1);
  assign flush_last = (step_r == len_m1);
  assign align_idx  = len_m1 - step_r;
  assign align_valid = (apwm_pkg::FILL_W'(align_idx) < fill_r);

  always_comb begin
    state_nxt      = state_r;
    seqpos_nxt     = seqpos_r;
    fill_nxt       = fill_r;
    step_nxt       = step_r;
    skip_nxt       = skip_r;
    fstart_nxt     = fstart_r;
    ev_nxt         = '0;
    ctrl           = '0;
    unique case (state_r)
      ST_STREAM: begin
        if (acc_sym) begin
          ctrl.shift     = 1'b1;
          ctrl.sym       = in_ch.symbol;
          ctrl.sym_valid = 1'b1;
          ctrl.clear     = (fill_r == '0);
          seqpos_nxt     = seqpos_inc;
          fill_nxt       = fill_inc;
          ev_nxt.valid   = full;
          ev_nxt.start   = start0;
          ev_nxt.closes  = !in_ch.end_of_sequence || (len_m1 == '0);
          if (in_ch.end_of_sequence) begin
            seqpos_nxt = '0;
            fill_nxt   = '0;
            if (len_m1 != '0) begin
              state_nxt  = ST_FLUSH;
              step_nxt   = apwm_pkg::LEN_W'(1);
              skip_nxt   = len_eff - top;
              fstart_nxt = start0 + 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        // advance the row one place per window, no new character behind it
        if (credit_ok) begin
          ctrl.shift    = 1'b1;
          ev_nxt.valid  = (step_r >= skip_r);
          ev_nxt.start  = fstart_r;
          ev_nxt.closes = flush_last;
          fstart_nxt    = fstart_r + 1'b1;
          step_nxt      = step_r + 1'b1;
          if (flush_last) begin
            state_nxt = ST_STREAM;
          end
        end
      end
      ST_ALIGN: begin
        // refill the row from history, oldest window character first
        ctrl.shift     = 1'b1;
        ctrl.sym       = hist_r[align_idx[apwm_pkg::IDX_W-1:0]];
        ctrl.sym_valid = align_valid;
        step_nxt       = step_r + 1'b1;
        if (flush_last) begin
          state_nxt = ST_STREAM;
        end
      end
      default: begin
        state_nxt = ST_STREAM;
      end
    endcase
    if (cfg_len_we) begin
      state_nxt = ST_ALIGN;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_STREAM;
      thr_r    <= apwm_pkg::THR_RESET;
      len_r    <= apwm_pkg::LEN_RESET;
      seqpos_r <= '0;
      fill_r   <= '0;
      step_r   <= '0;
      ev_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      seqpos_r <= seqpos_nxt;
      fill_r   <= fill_nxt;
      step_r   <= step_nxt;
      ev_r     <= ev_nxt;
      if (cfg_we && (cfg_index == apwm_pkg::CFG_THRESHOLD)) begin
        thr_r <= cfg_data[apwm_pkg::THR_W-1:0];
      end
      if (cfg_len_we) begin
        len_r <= cfg_data[apwm_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    skip_r    <= skip_nxt;
    fstart_r  <= fstart_nxt;
    thr_len_r <= apwm_pkg::PROD_W'(thr_r) * apwm_pkg::PROD_W'(len_eff);
    if (acc_sym) begin
      hist_r[0] <= in_ch.symbol;
      for (int k = 1; k < PM; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < PM; j++) begin : g_cell
    logic [apwm_pkg::SYM_W-1:0] nb_sym;
    logic                       nb_valid;
    if (j == PM - 1) begin : g_end
      assign nb_sym   = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_sym   = cell_sym[j+1];
      assign nb_valid = cell_valid[j+1];
    end
    apwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .inject   (len_m1 == apwm_pkg::LEN_W'(j)),
      .in_use   (apwm_pkg::LEN_W'(j) < len_eff),
      .pat_we   (acc_pat && (in_ch.pattern_index == apwm_pkg::IDX_W'(j))),
      .pat_sym  (in_ch.symbol),
      .nb_sym   (nb_sym),
      .nb_valid (nb_valid),
      .sym      (cell_sym[j]),
      .valid    (cell_valid[j]),
      .hit      (hits[j])
    );
  end

  apwm_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev_r),
    .hits      (hits),
    .thr_len   (thr_len_r),
    .push      (push),
    .push_word (push_word),
    .occ       (score_occ)
  );

  apwm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop_ready  (out_ch.ready),
    .head_valid (out_ch.valid),
    .head_word  (head_word),
    .count      (fifo_cnt)
  );

  assign out_ch.start_position = head_word.start_position;
  assign out_ch.match_count    = head_word.match_count;
  assign out_ch.match_mask     = head_word.match_mask;
  assign out_ch.last_of_run    = head_word.last_of_run;

endmodule

// ===== src/apwm_checker.sv =====
module apwm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_we,
  input logic [apwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [apwm_pkg::POS_W-1:0]      start_position,
  input logic [apwm_pkg::CNT_W-1:0]      match_count,
  input logic [apwm_pkg::MASK_W-1:0]     match_mask,
  input logic                            last_of_run
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(start_position) && $stable(match_count) &&
      $stable(match_mask) && $stable(last_of_run))
    else $error("result word changed while stalled");

  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(match_mask) == int'(match_count)))
    else $error("match count disagrees with match mask");

  // a new pattern length realigns the cell row before more input
  a_len_realign: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == apwm_pkg::CFG_LENGTH) |=> !in_ready)
    else $error("input taken right after a pattern length write");

endmodule

bind approximate_pattern_window_matcher_unit apwm_checker u_apwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .start_position (out_ch.start_position),
  .match_count    (out_ch.match_count),
  .match_mask     (out_ch.match_mask),
  .last_of_run    (out_ch.last_of_run)
);
